### src/stream_rank_tracker_unit_defines.svh
// Assertion macros for the stream rank tracker.
// Used by modules that take clk and arst_n as their clock and reset.
`ifndef STREAM_RANK_TRACKER_UNIT_DEFINES_SVH
`define STREAM_RANK_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication
`define SRT_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/srt_pkg.sv
// Shared types and constants for the stream rank tracker.
// No dependencies.
package srt_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned OUT_W   = 7;

	typedef enum logic {
		OP_TRACK = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

	typedef struct packed {
		logic    valid;
		opcode_t op;
		logic    drop;
	} stage_ctl_t;

endpackage

### src/srt_item_if.sv
// Input channel of the stream rank tracker: valid/ready plus item payload.
// Depends on srt_pkg.
interface srt_item_if;
	logic                                valid;
	logic                                ready;
	logic                                opcode;
	logic signed [srt_pkg::VALUE_W-1:0]  item_value;

	modport source(output valid, opcode, item_value, input ready);
	modport sink(input valid, opcode, item_value, output ready);
endinterface

### src/srt_result_if.sv
// Result channel of the stream rank tracker: valid/ready plus result payload.
// Depends on srt_pkg.
interface srt_result_if;
	logic                        valid;
	logic                        ready;
	logic [srt_pkg::OUT_W-1:0]   rank_count;
	logic                        dropped;
	logic [srt_pkg::OUT_W-1:0]   stored_count;

	modport source(output valid, rank_count, dropped, stored_count, input ready);
	modport sink(input valid, rank_count, dropped, stored_count, output ready);
endinterface

### src/stream_rank_tracker_unit.sv
// Top level of the stream rank tracker: entry logic, chain of srt_cell, result register.
// Depends on srt_pkg, srt_item_if, srt_result_if, srt_cell and the defines header.
//
//  channel | dir | beat payload
//  --------+-----+-------------------------------------------
//  items   | in  | opcode, item_value
//  results | out | rank_count, dropped, stored_count
//
// One beat per cycle unless results stall; one cell per store entry.
// Every beat passes each cell and the result register; one result beat each, in order.
// A stalled results channel halts the whole chain and items.ready drops.
// Reset clears the fill count and stage valid bits; no clearing pass is needed.
`include "stream_rank_tracker_unit_defines.svh"

module stream_rank_tracker_unit #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	srt_item_if.sink           items,
	srt_result_if.source       results
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned EW = (CW > srt_pkg::OUT_W) ? CW : srt_pkg::OUT_W;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	srt_pkg::stage_ctl_t                ctl_w    [CAPACITY+1];
	logic signed [srt_pkg::VALUE_W-1:0] value_w  [CAPACITY+1];
	logic [CW-1:0]                      idx_w    [CAPACITY+1];
	logic [CW-1:0]                      less_w   [CAPACITY+1];
	logic [CW-1:0]                      eq_w     [CAPACITY+1];
	logic [CW-1:0]                      stored_w [CAPACITY+1];

	logic          adv;
	logic          in_track;
	logic          full;
	logic          take;
	logic [CW-1:0] fill_q;

	logic              out_valid_q;
	logic              out_drop_q;
	srt_pkg::opcode_t  out_op_q;
	logic [CW-1:0]     out_rank_q;
	logic [CW-1:0]     out_stored_q;
	logic [CW-1:0]     rank_d;
	logic [EW-1:0]     rank_ext;
	logic [EW-1:0]     stored_ext;

	assign adv      = !out_valid_q || results.ready;
	assign items.ready = adv;
	assign in_track = (items.opcode == srt_pkg::OP_TRACK);
	assign full     = (fill_q == CAP_C);
	assign take     = items.valid && adv && in_track && !full;

	assign ctl_w[0].valid = items.valid;
	assign ctl_w[0].op    = srt_pkg::opcode_t'(items.opcode);
	assign ctl_w[0].drop  = in_track && full;
	assign value_w[0]     = items.item_value;
	assign idx_w[0]       = fill_q;
	assign less_w[0]      = '0;
	assign eq_w[0]        = '0;
	assign stored_w[0]    = (in_track && !full) ? fill_q + CW'(1) : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (take) begin
			fill_q <= fill_q + CW'(1);
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		srt_cell #(
			.INDEX(i),
			.CW   (CW)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.ctl_in   (ctl_w[i]),
			.value_in (value_w[i]),
			.idx_in   (idx_w[i]),
			.less_in  (less_w[i]),
			.eq_in    (eq_w[i]),
			.stored_in(stored_w[i]),
			.ctl_s1   (ctl_w[i+1]),
			.value_s1 (value_w[i+1]),
			.idx_s1   (idx_w[i+1]),
			.less_s1  (less_w[i+1]),
			.eq_s1    (eq_w[i+1]),
			.stored_s1(stored_w[i+1])
		);
	end

	always_comb begin
		if (ctl_w[CAPACITY].op != srt_pkg::OP_QUERY) begin
			rank_d = '0;
		end else if (eq_w[CAPACITY] != '0) begin
			rank_d = less_w[CAPACITY] + eq_w[CAPACITY] - CW'(1);
		end else begin
			rank_d = less_w[CAPACITY];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_w[CAPACITY].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_drop_q   <= ctl_w[CAPACITY].drop;
			out_op_q     <= ctl_w[CAPACITY].op;
			out_rank_q   <= rank_d;
			out_stored_q <= stored_w[CAPACITY];
		end
	end

	// counts wrap to the port width
	assign rank_ext             = EW'(out_rank_q);
	assign stored_ext           = EW'(out_stored_q);
	assign results.valid        = out_valid_q;
	assign results.rank_count   = rank_ext[srt_pkg::OUT_W-1:0];
	assign results.stored_count = stored_ext[srt_pkg::OUT_W-1:0];
	assign results.dropped      = out_drop_q;

	`SRT_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= CAP_C, "fill count above capacity")
	`SRT_ASSERT_NEXT(a_fill_step, take, fill_q == $past(fill_q) + CW'(1), "fill count missed a track beat")
	`SRT_ASSERT_IMPL(a_drop_full, out_valid_q && out_drop_q, (out_stored_q == CAP_C) && (out_rank_q == '0), "drop reported below capacity")
	`SRT_ASSERT_IMPL(a_rank_bound, out_valid_q && (out_op_q == srt_pkg::OP_QUERY), (out_rank_q <= out_stored_q) && !out_drop_q, "rank above stored count")

endmodule

### src/srt_cell.sv
// One cell of the rank chain: holds one stored value, compares passing queries
// against it, captures the track beat aimed at it. Depends on srt_pkg.
module srt_cell #(
	parameter int unsigned INDEX = 0,
	parameter int unsigned CW    = 7
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  srt_pkg::stage_ctl_t                ctl_in,
	input  logic signed [srt_pkg::VALUE_W-1:0] value_in,
	input  logic [CW-1:0]                      idx_in,
	input  logic [CW-1:0]                      less_in,
	input  logic [CW-1:0]                      eq_in,
	input  logic [CW-1:0]                      stored_in,
	output srt_pkg::stage_ctl_t                ctl_s1,
	output logic signed [srt_pkg::VALUE_W-1:0] value_s1,
	output logic [CW-1:0]                      idx_s1,
	output logic [CW-1:0]                      less_s1,
	output logic [CW-1:0]                      eq_s1,
	output logic [CW-1:0]                      stored_s1
);

	localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

	logic signed [srt_pkg::VALUE_W-1:0] cell_value_q;
	logic                               wr_en;
	logic                               live;
	logic                               lt;
	logic                               eq;

	assign wr_en = adv && ctl_in.valid && (ctl_in.op == srt_pkg::OP_TRACK)
		&& !ctl_in.drop && (idx_in == MY_IDX);
	// for a query, idx carries the fill count seen at entry
	assign live  = ctl_in.valid && (ctl_in.op == srt_pkg::OP_QUERY) && (MY_IDX < idx_in);
	assign lt    = live && (cell_value_q < value_in);
	assign eq    = live && (cell_value_q == value_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_s1  <= value_in;
			idx_s1    <= idx_in;
			less_s1   <= less_in + CW'(lt);
			eq_s1     <= eq_in + CW'(eq);
			stored_s1 <= stored_in;
		end
		if (wr_en) begin
			cell_value_q <= value_in;
		end
	end

endmodule
